/* src/awd_pkg.sv */
`default_nettype none

package awd_pkg;

  localparam logic [15:0] HALF_ONE  = 16'h3C00;
  localparam logic [15:0] HALF_QNAN = 16'h7E00;
  localparam logic [15:0] HALF_INF  = 16'h7C00;
  localparam logic [15:0] HALF_ZERO = 16'h0000;

  localparam int CFG_INDEX_W = 3;

  // Register reset values (binary32) and their binary16 images.
  localparam logic [31:0] LR_RESET    = 32'h0000_0000;
  localparam logic [31:0] BETA1_RESET = 32'h3F66_6666;
  localparam logic [31:0] BETA2_RESET = 32'h3F7F_BE77;
  localparam logic [31:0] EPS_RESET   = 32'h3586_37BD;
  localparam logic [31:0] DECAY_RESET = 32'h0000_0000;
  localparam logic [15:0] LR_H_RESET    = 16'h0000;
  localparam logic [15:0] BETA1_H_RESET = 16'h3B33;
  localparam logic [15:0] BETA2_H_RESET = 16'h3BFE;
  localparam logic [15:0] B1M_H_RESET   = 16'h2E68;
  localparam logic [15:0] B2M_H_RESET   = 16'h1400;
  localparam logic [15:0] EPS_H_RESET   = 16'h0011;
  localparam logic [15:0] DECAY_H_RESET = 16'h0000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LR    = 3'd0,
    REG_BETA1 = 3'd1,
    REG_BETA2 = 3'd2,
    REG_EPS   = 3'd3,
    REG_DECAY = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] weight_in;
    logic [15:0] first_moment_in;
    logic [15:0] second_moment_in;
    logic [15:0] gradient_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] weight_out;
    logic [15:0] first_moment_out;
    logic [15:0] second_moment_out;
  } out_item_t;

  // Unpacked operand: significand normalized with bit 10 set, value sig * 2^(exp-10).
  typedef struct packed {
    logic              sign;
    logic              nan;
    logic              inf;
    logic              zero;
    logic signed [8:0] exp;
    logic [10:0]       sig;
  } fp_t;

  function automatic fp_t unpack(input logic [15:0] h);
    fp_t        r;
    logic [9:0] f;
    logic [3:0] p;
    f = h[9:0];
    p = 4'd0;
    r.sign = h[15];
    r.nan  = (h[14:10] == 5'h1F) && (f != 10'd0);
    r.inf  = (h[14:10] == 5'h1F) && (f == 10'd0);
    r.zero = (h[14:0] == 15'd0);
    if (h[14:10] != 5'd0) begin
      r.exp = $signed({4'b0, h[14:10]}) - 9'sd15;
      r.sig = {1'b1, f};
    end else begin
      for (int i = 0; i < 10; i++) begin
        if (f[i]) p = 4'(i);
      end
      r.exp = $signed({5'b0, p}) - 9'sd24;
      r.sig = {1'b0, f} << (4'd10 - p);
    end
    return r;
  endfunction

  // Round m (MSB at bit 13 = 2^e) plus sticky to binary16, nearest-even.
  function automatic logic [15:0] round_pack(input logic sign, input logic signed [8:0] e,
                                             input logic [13:0] m, input logic st);
    logic [3:0]  sh;
    logic [4:0]  ebase;
    logic [13:0] val;
    logic [13:0] mask;
    logic        s2;
    logic        up;
    logic [10:0] q;
    logic [15:0] bits;
    if (m == 14'd0) return {sign, 15'd0};
    if (e > 9'sd15) return {sign, HALF_INF[14:0]};
    if (e < -9'sd14) begin
      ebase = 5'd0;
      if (e < -9'sd29) sh = 4'd15;
      else sh = 4'(-9'sd14 - e);
    end else begin
      sh    = 4'd0;
      ebase = 5'(e + 9'sd14);
    end
    val  = m >> sh;
    mask = (14'h1 << sh) - 14'h1;
    s2   = st | ((m & mask) != 14'd0) | (|val[1:0]);
    q    = val[13:3];
    up   = val[2] & (s2 | q[0]);
    bits = {1'b0, ebase, 10'd0} + {5'd0, q} + {15'd0, up};
    if (bits[14:0] >= HALF_INF[14:0]) bits = HALF_INF;
    return {sign, bits[14:0]};
  endfunction

  function automatic logic [15:0] h_mul(input logic [15:0] a, input logic [15:0] b);
    fp_t               x;
    fp_t               y;
    logic              s;
    logic [21:0]       p;
    logic signed [8:0] e;
    logic [13:0]       m;
    logic              st;
    x = unpack(a);
    y = unpack(b);
    s = a[15] ^ b[15];
    if (x.nan || y.nan || (x.inf && y.zero) || (x.zero && y.inf)) return HALF_QNAN;
    if (x.inf || y.inf) return {s, HALF_INF[14:0]};
    if (x.zero || y.zero) return {s, 15'd0};
    p = x.sig * y.sig;
    if (p[21]) begin
      e  = x.exp + y.exp + 9'sd1;
      m  = p[21:8];
      st = |p[7:0];
    end else begin
      e  = x.exp + y.exp;
      m  = p[20:7];
      st = |p[6:0];
    end
    return round_pack(s, e, m, st);
  endfunction

  function automatic logic [15:0] h_add(input logic [15:0] a, input logic [15:0] b);
    fp_t               x;
    fp_t               y;
    fp_t               big;
    fp_t               sml;
    logic signed [8:0] dd;
    logic [3:0]        d;
    logic [13:0]       ab;
    logic [13:0]       bb;
    logic [13:0]       shb;
    logic [14:0]       s;
    logic [14:0]       n;
    logic [3:0]        p;
    logic signed [8:0] e;
    x = unpack(a);
    y = unpack(b);
    p = 4'd0;
    if (x.nan || y.nan) return HALF_QNAN;
    if (x.inf && y.inf && (a[15] != b[15])) return HALF_QNAN;
    if (x.inf) return a;
    if (y.inf) return b;
    if (x.zero && y.zero) return {a[15] & b[15], 15'd0};
    if (x.zero) return b;
    if (y.zero) return a;
    if ((x.exp > y.exp) || ((x.exp == y.exp) && (x.sig >= y.sig))) begin
      big = x;
      sml = y;
    end else begin
      big = y;
      sml = x;
    end
    dd  = big.exp - sml.exp;
    d   = (dd > 9'sd15) ? 4'd15 : dd[3:0];
    ab  = {big.sig, 3'b000};
    bb  = {sml.sig, 3'b000};
    shb = bb >> d;
    shb[0] = shb[0] | ((bb & ((14'h1 << d) - 14'h1)) != 14'd0);
    if (big.sign ^ sml.sign) s = {1'b0, ab} - {1'b0, shb};
    else s = {1'b0, ab} + {1'b0, shb};
    if (s == 15'd0) return HALF_ZERO;
    for (int i = 0; i < 15; i++) begin
      if (s[i]) p = 4'(i);
    end
    n = s << (4'd14 - p);
    e = big.exp + $signed({5'b0, p}) - 9'sd13;
    return round_pack(big.sign, e, n[14:1], n[0]);
  endfunction

  function automatic logic [15:0] h_sub(input logic [15:0] a, input logic [15:0] b);
    return h_add(a, {~b[15], b[14:0]});
  endfunction

  function automatic logic [15:0] f32_to_h(input logic [31:0] f);
    if (f[30:23] == 8'hFF) begin
      if (f[22:0] != 23'd0) return HALF_QNAN;
      return {f[31], HALF_INF[14:0]};
    end
    if (f[30:23] == 8'd0) return {f[31], 15'd0};
    return round_pack(f[31], $signed({1'b0, f[30:23]}) - 9'sd127, {1'b1, f[22:10]},
                      |f[9:0]);
  endfunction

endpackage

`default_nettype wire

/* src/adam_weight_decay_update.sv */
`default_nettype none

// AdamW element update in binary16, no bias correction. Each transfer on the
// item channel carries one weight, first moment, second moment and gradient;
// each transfer on the result channel returns the new weight and moments.
// Every arithmetic step rounds to binary16, nearest-even, with canonical
// quiet NaN 0x7E00. The block takes one item per cycle for as long as the
// result side keeps up; each item passes through a sixteen-stage pipeline,
// the result register being the last stage, of which the square root and
// the divide take four stages each. The whole pipeline holds when the
// result register is full and not taken. Write the five binary32 registers
// (index 0..4: learning rate, beta1, beta2, epsilon, decay) only while the
// pipeline is empty; their binary16 images are registered from them, and
// 1 - beta is registered in turn from those images.
module adam_weight_decay_update (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             item_valid,
  output logic                                  item_ready,
  input  wire awd_pkg::in_item_t                item,
  output logic                                  result_valid,
  input  wire logic                             result_ready,
  output awd_pkg::out_item_t                    result,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [awd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [31:0]                      cfg_data
);
  import awd_pkg::*;

  // Payload of one pipeline stage; x and y hold the intermediates.
  typedef struct packed {
    logic [15:0] w;
    logic [15:0] m;
    logic [15:0] v;
    logic [15:0] wd;
    logic [15:0] x;
    logic [15:0] y;
  } stage_t;

  logic [31:0] lr_raw;
  logic [31:0] beta1_raw;
  logic [31:0] beta2_raw;
  logic [31:0] eps_raw;
  logic [31:0] decay_raw;
  logic [15:0] lr_h;
  logic [15:0] beta1_h;
  logic [15:0] beta2_h;
  logic [15:0] eps_h;
  logic [15:0] decay_h;
  logic [15:0] b1m_h;
  logic [15:0] b2m_h;

  logic        adv;
  logic [16:1] vld;
  stage_t      pipe [1:15];
  stage_t      pipe_next [1:15];
  out_item_t   result_next;
  logic [15:0] root_h;
  logic [15:0] quot_h;

  // Configuration: always ready, writes beyond the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lr_raw    <= LR_RESET;
      beta1_raw <= BETA1_RESET;
      beta2_raw <= BETA2_RESET;
      eps_raw   <= EPS_RESET;
      decay_raw <= DECAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LR:    lr_raw    <= cfg_data;
        REG_BETA1: beta1_raw <= cfg_data;
        REG_BETA2: beta2_raw <= cfg_data;
        REG_EPS:   eps_raw   <= cfg_data;
        REG_DECAY: decay_raw <= cfg_data;
        default: ;
      endcase
    end
  end

  // Narrow the registers to binary16, and form 1 - beta from them in the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      lr_h    <= LR_H_RESET;
      beta1_h <= BETA1_H_RESET;
      beta2_h <= BETA2_H_RESET;
      eps_h   <= EPS_H_RESET;
      decay_h <= DECAY_H_RESET;
      b1m_h   <= B1M_H_RESET;
      b2m_h   <= B2M_H_RESET;
    end else begin
      lr_h    <= f32_to_h(lr_raw);
      beta1_h <= f32_to_h(beta1_raw);
      beta2_h <= f32_to_h(beta2_raw);
      eps_h   <= f32_to_h(eps_raw);
      decay_h <= f32_to_h(decay_raw);
      b1m_h   <= h_sub(HALF_ONE, beta1_h);
      b2m_h   <= h_sub(HALF_ONE, beta2_h);
    end
  end

  // Advance the whole pipeline unless a finished result waits untaken.
  assign adv          = !vld[16] || result_ready;
  assign item_ready   = adv;
  assign result_valid = vld[16];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[15:1], item_valid};
    end
  end

  // Square root of v' runs in stages 5..8, the divide in stages 10..13.
  awd_root u_root (
    .clk  (clk),
    .en   (adv),
    .h    (pipe[4].v),
    .root (root_h)
  );

  awd_div u_div (
    .clk (clk),
    .en  (adv),
    .num (pipe[9].m),
    .den (pipe[9].x),
    .quo (quot_h)
  );

  always_comb begin
    for (int k = 1; k <= 15; k++) begin
      pipe_next[k] = (k == 1) ? pipe[1] : pipe[k-1];
    end
    // Stage 1: g - m, g*g and decay*w side by side.
    pipe_next[1].w  = item.weight_in;
    pipe_next[1].m  = item.first_moment_in;
    pipe_next[1].v  = item.second_moment_in;
    pipe_next[1].wd = h_mul(decay_h, item.weight_in);
    pipe_next[1].x  = h_sub(item.gradient_in, item.first_moment_in);
    pipe_next[1].y  = h_mul(item.gradient_in, item.gradient_in);
    // Stage 2: scale the first-moment delta, form g*g - v.
    pipe_next[2].x  = h_mul(pipe[1].x, b1m_h);
    pipe_next[2].y  = h_sub(pipe[1].y, pipe[1].v);
    // Stage 3: new first moment, scale the second-moment delta.
    pipe_next[3].m  = h_add(pipe[2].m, pipe[2].x);
    pipe_next[3].y  = h_mul(pipe[2].y, b2m_h);
    // Stage 4: new second moment.
    pipe_next[4].v  = h_add(pipe[3].v, pipe[3].y);
    // Stage 9: denominator.
    pipe_next[9].x  = h_add(root_h, eps_h);
    // Stage 14: quotient plus decay term.
    pipe_next[14].x = h_add(quot_h, pipe[13].wd);
    // Stage 15: scale by learning rate.
    pipe_next[15].x = h_mul(lr_h, pipe[14].x);
    // Stage 16: result register.
    result_next.weight_out        = h_sub(pipe[15].w, pipe[15].x);
    result_next.first_moment_out  = pipe[15].m;
    result_next.second_moment_out = pipe[15].v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k <= 15; k++) begin
        pipe[k] <= pipe_next[k];
      end
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

/* src/awd_root.sv */
`default_nettype none

// Correctly rounded binary16 square root, four register stages, one
// result bit per recurrence step.
module awd_root (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [15:0] h,
  output logic [15:0]      root
);
  import awd_pkg::*;

  typedef struct packed {
    logic              spec;
    logic [15:0]       sval;
    logic signed [8:0] e;
    logic [27:0]       rad;
    logic [15:0]       rem;
    logic [13:0]       q;
  } sq_t;

  sq_t         pre;
  sq_t         st1;
  sq_t         st2;
  sq_t         st3;
  sq_t         st1_next;
  sq_t         st2_next;
  sq_t         st3_next;
  sq_t         fin;
  logic [15:0] root_next;

  function automatic sq_t steps(input sq_t s, input int hi, input int lo);
    sq_t         r;
    logic [17:0] r2;
    logic [17:0] t;
    r = s;
    for (int i = 13; i >= 0; i--) begin
      if (i <= hi && i >= lo) begin
        r2 = {r.rem, r.rad[2*i+1 -: 2]};
        t  = {2'b00, r.q, 2'b01};
        if (r2 >= t) begin
          r.rem = 16'(r2 - t);
          r.q   = {r.q[12:0], 1'b1};
        end else begin
          r.rem = r2[15:0];
          r.q   = {r.q[12:0], 1'b0};
        end
      end
    end
    return r;
  endfunction

  always_comb begin
    fp_t        x;
    logic [11:0] xs;
    x = unpack(h);
    xs = x.exp[0] ? {x.sig, 1'b0} : {1'b0, x.sig};
    pre.spec = 1'b1;
    pre.sval = HALF_QNAN;
    if (x.nan) begin
      pre.sval = HALF_QNAN;
    end else if (x.zero) begin
      pre.sval = h;
    end else if (x.sign) begin
      pre.sval = HALF_QNAN;
    end else if (x.inf) begin
      pre.sval = HALF_INF;
    end else begin
      pre.spec = 1'b0;
    end
    pre.e   = (x.exp - $signed({8'd0, x.exp[0]})) >>> 1;
    pre.rad = {xs, 16'd0};
    pre.rem = 16'd0;
    pre.q   = 14'd0;
    st1_next = steps(pre, 13, 10);
    st2_next = steps(st1, 9, 6);
    st3_next = steps(st2, 5, 3);
    fin      = steps(st3, 2, 0);
    root_next = fin.spec ? fin.sval : round_pack(1'b0, fin.e, fin.q, fin.rem != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1  <= st1_next;
      st2  <= st2_next;
      st3  <= st3_next;
      root <= root_next;
    end
  end

endmodule

`default_nettype wire

/* src/awd_div.sv */
`default_nettype none

// Correctly rounded binary16 divide, four register stages of restoring
// recurrence, one quotient bit per step.
module awd_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [15:0] num,
  input  wire logic [15:0] den,
  output logic [15:0]      quo
);
  import awd_pkg::*;

  typedef struct packed {
    logic              spec;
    logic [15:0]       sval;
    logic              sign;
    logic signed [8:0] e;
    logic [10:0]       b;
    logic [11:0]       r;
    logic [13:0]       q;
  } dv_t;

  dv_t         pre;
  dv_t         st1;
  dv_t         st2;
  dv_t         st3;
  dv_t         st1_next;
  dv_t         st2_next;
  dv_t         st3_next;
  dv_t         fin;
  logic [15:0] quo_next;

  function automatic dv_t steps(input dv_t s, input int n);
    dv_t         r;
    logic [11:0] r1;
    logic        qb;
    r = s;
    for (int i = 0; i < 4; i++) begin
      if (i < n) begin
        qb = (r.r >= {1'b0, r.b});
        r1 = qb ? (r.r - {1'b0, r.b}) : r.r;
        r.q = {r.q[12:0], qb};
        r.r = {r1[10:0], 1'b0};
      end
    end
    return r;
  endfunction

  always_comb begin
    fp_t x;
    fp_t y;
    x = unpack(num);
    y = unpack(den);
    pre.sign = num[15] ^ den[15];
    pre.spec = 1'b1;
    pre.sval = HALF_QNAN;
    if (x.nan || y.nan) begin
      pre.sval = HALF_QNAN;
    end else if (y.zero) begin
      pre.sval = x.zero ? HALF_QNAN : {pre.sign, HALF_INF[14:0]};
    end else if (x.inf && y.inf) begin
      pre.sval = HALF_QNAN;
    end else if (x.inf) begin
      pre.sval = {pre.sign, HALF_INF[14:0]};
    end else if (y.inf || x.zero) begin
      pre.sval = {pre.sign, 15'd0};
    end else begin
      pre.spec = 1'b0;
    end
    pre.e = x.exp - y.exp;
    pre.b = y.sig;
    pre.r = {1'b0, x.sig};
    pre.q = 14'd0;
    st1_next = steps(pre, 4);
    st2_next = steps(st1, 4);
    st3_next = steps(st2, 3);
    fin      = steps(st3, 3);
    if (fin.spec) begin
      quo_next = fin.sval;
    end else if (fin.q[13]) begin
      quo_next = round_pack(fin.sign, fin.e, fin.q, fin.r != 12'd0);
    end else begin
      quo_next = round_pack(fin.sign, fin.e - 9'sd1, {fin.q[12:0], 1'b0}, fin.r != 12'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1 <= st1_next;
      st2 <= st2_next;
      st3 <= st3_next;
      quo <= quo_next;
    end
  end

endmodule

`default_nettype wire

/* src/awd_check.sv */
`default_nettype none

module awd_check (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               item_ready,
  input wire logic               result_valid,
  input wire logic               result_ready,
  input wire awd_pkg::out_item_t result,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready
);

  // Hold a stalled result.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result dropped or changed");

  // Take items whenever the result register is empty.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("item not taken with empty output");

  // Freeze intake while a result is stalled.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !item_ready)
    else $error("item taken while pipeline stalled");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration transfer refused");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule

bind adam_weight_decay_update awd_check u_awd_check (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import awd_pkg::*;

  // Any register index past the last one; the block must drop the write.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam logic [15:0] F16_QNAN = 16'h7E00;
  localparam logic [15:0] F16_INF  = 16'h7C00;
  localparam int          RANDOM_ITEMS = 430;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_ready;
  in_item_t   item = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  out_item_t  result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  adam_weight_decay_update dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the five binary32 registers, as the block holds them.
  logic [31:0] lr_bits, beta1_bits, beta2_bits, eps_bits, decay_bits;

  out_item_t pending_updates[$];
  int        fail_count = 0;
  int        checked_count = 0;
  int        phase_count = 0;
  bit        long_hold_req = 1'b0;

  // ---------------------------------------------------------------------
  // binary16 arithmetic: carry each operand to a double, do the operation
  // there (exact for add/sub/mul, correctly rounded for div), round back.
  // ---------------------------------------------------------------------
  function automatic real half_val(logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  f;
    logic [63:0] b;
    real         d;
    e = h[14:10];
    f = h[9:0];
    if (e == 5'h1F) begin
      b = {h[15], 11'h7FF, f, 42'd0};
      if (f != 10'd0) b[51] = 1'b1;
      return $bitstoreal(b);
    end
    if (e == 5'd0) begin
      d = real'(f) * 5.9604644775390625e-08;
      return h[15] ? -d : d;
    end
    b = {h[15], 11'(int'(e) - 15 + 1023), f, 42'd0};
    return $bitstoreal(b);
  endfunction

  function automatic logic [15:0] to_half(real x);
    logic [63:0] u, mant, q, rem, halfway;
    logic [15:0] sgn;
    logic [31:0] bits;
    int          ex, he, sh;
    u   = $realtobits(x);
    sgn = {u[63], 15'd0};
    ex  = int'(u[62:52]);
    if (ex == 2047) begin
      if (u[51:0] != 52'd0) return F16_QNAN;
      return sgn | F16_INF;
    end
    if (ex == 0) return sgn;
    he = ex - 1023 + 15;
    if (he > 30) return sgn | F16_INF;
    mant = {12'd1, u[51:0]};
    sh = (he >= 1) ? 42 : 42 + (1 - he);
    if (sh > 60) return sgn;
    q       = mant >> sh;
    rem     = mant & ((64'd1 << sh) - 64'd1);
    halfway = 64'd1 << (sh - 1);
    if (rem > halfway || (rem == halfway && q[0])) q = q + 64'd1;
    if (he >= 1) bits = (32'(he - 1) << 10) + q[31:0];
    else bits = q[31:0];
    if (bits >= 32'h7C00) bits = 32'h7C00;
    return sgn | bits[15:0];
  endfunction

  function automatic logic [15:0] single_to_half(logic [31:0] f);
    logic [63:0] b;
    real         d;
    if (f[30:23] == 8'hFF) begin
      b = {f[31], 11'h7FF, f[22:0], 29'd0};
      if (f[22:0] != 23'd0) b[51] = 1'b1;
      return to_half($bitstoreal(b));
    end
    if (f[30:23] == 8'd0) begin
      d = real'(f[22:0]) * (2.0 ** -149);
      return to_half(f[31] ? -d : d);
    end
    b = {f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'd0};
    return to_half($bitstoreal(b));
  endfunction

  function automatic bit half_is_nan(logic [15:0] h);
    return h[14:10] == 5'h1F && h[9:0] != 10'd0;
  endfunction

  function automatic logic [15:0] f16_add(logic [15:0] a, logic [15:0] b);
    return to_half(half_val(a) + half_val(b));
  endfunction

  function automatic logic [15:0] f16_sub(logic [15:0] a, logic [15:0] b);
    return to_half(half_val(a) - half_val(b));
  endfunction

  function automatic logic [15:0] f16_mul(logic [15:0] a, logic [15:0] b);
    return to_half(half_val(a) * half_val(b));
  endfunction

  function automatic logic [15:0] f16_div(logic [15:0] a, logic [15:0] b);
    if (b[14:0] == 15'd0) begin
      if (half_is_nan(a) || a[14:0] == 15'd0) return F16_QNAN;
      return {a[15] ^ b[15], F16_INF[14:0]};
    end
    return to_half(half_val(a) / half_val(b));
  endfunction

  function automatic logic [15:0] f16_sqrt(logic [15:0] h);
    int  lo, hi, mid;
    real v, md, lo_d, hi_d, center;
    if (half_is_nan(h)) return F16_QNAN;
    if (h[14:0] == 15'd0) return h;
    if (h[15]) return F16_QNAN;
    if (h == F16_INF) return F16_INF;
    v  = half_val(h);
    lo = 0;
    hi = 'h7BFF;
    // largest half whose square stays at or below v
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      md  = half_val(16'(mid));
      if (md * md <= v) lo = mid;
      else hi = mid - 1;
    end
    lo_d   = half_val(16'(lo));
    hi_d   = half_val(16'(lo + 1));
    center = (lo_d + hi_d) * 0.5;
    if (v > center * center) return 16'(lo + 1);
    if (v < center * center) return 16'(lo);
    return lo[0] ? 16'(lo + 1) : 16'(lo);
  endfunction

  // One AdamW step under the current shadow registers.
  function automatic out_item_t adamw_step(in_item_t x);
    logic [15:0] lr, b1m, b2m, eps, dec, m_new, v_new, den, upd;
    out_item_t   r;
    lr    = single_to_half(lr_bits);
    b1m   = f16_sub(16'h3C00, single_to_half(beta1_bits));
    b2m   = f16_sub(16'h3C00, single_to_half(beta2_bits));
    eps   = single_to_half(eps_bits);
    dec   = single_to_half(decay_bits);
    m_new = f16_add(x.first_moment_in,
                    f16_mul(f16_sub(x.gradient_in, x.first_moment_in), b1m));
    v_new = f16_add(x.second_moment_in,
                    f16_mul(f16_sub(f16_mul(x.gradient_in, x.gradient_in),
                                    x.second_moment_in), b2m));
    den   = f16_add(f16_sqrt(v_new), eps);
    upd   = f16_add(f16_div(m_new, den), f16_mul(dec, x.weight_in));
    r.weight_out        = f16_sub(x.weight_in, f16_mul(lr, upd));
    r.first_moment_out  = m_new;
    r.second_moment_out = v_new;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: stall on a rotating pattern, or hold off for a long
  // stretch on request so the pipeline backs up into the item channel.
  // ---------------------------------------------------------------------
  int rx_cycle = 0;
  int rx_hold = 0;

  always @(posedge clk) begin
    rx_cycle++;
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      rx_hold = 120;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      result_ready <= 1'b0;
    end else begin
      case ((rx_cycle / 97) % 3)
        0: result_ready <= 1'b1;
        1: result_ready <= ($urandom_range(99) >= 30);
        default: result_ready <= ($urandom_range(99) >= 75);
      endcase
    end
  end

  // Check every result transfer against the oldest pending update.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, result);
        fail_count++;
      end else begin
        want = pending_updates.pop_front();
        checked_count++;
        if (result.weight_out !== want.weight_out) begin
          $display("%0t: weight_out expected %h actual %h",
                   $realtime, want.weight_out, result.weight_out);
          fail_count++;
        end
        if (result.first_moment_out !== want.first_moment_out) begin
          $display("%0t: first_moment_out expected %h actual %h",
                   $realtime, want.first_moment_out, result.first_moment_out);
          fail_count++;
        end
        if (result.second_moment_out !== want.second_moment_out) begin
          $display("%0t: second_moment_out expected %h actual %h",
                   $realtime, want.second_moment_out, result.second_moment_out);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Drivers. Each task starts and returns just after a rising edge.
  // ---------------------------------------------------------------------
  task automatic send_item(in_item_t x, bit typed, out_item_t typed_update);
    item_valid <= 1'b1;
    item       <= x;
    do @(posedge clk); while (!item_ready);
    pending_updates.push_back(typed ? typed_update : adamw_step(x));
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LR:    lr_bits    = data;
      REG_BETA1: beta1_bits = data;
      REG_BETA2: beta2_bits = data;
      REG_EPS:   eps_bits   = data;
      REG_DECAY: decay_bits = data;
      default: ;
    endcase
    // let the binary16 images settle
    repeat (4) @(posedge clk);
  endtask

  // Drain: wait out every pending update, then the pipeline depth.
  task automatic drain;
    item_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Mostly plausible optimizer values with a tail of raw bit patterns.
  function automatic logic [15:0] pick_half(int spread);
    if ($urandom_range(99) < 20) return 16'($urandom);
    return {1'($urandom), 5'($urandom_range(15 + spread, 15 - spread)), 10'($urandom)};
  endfunction

  function automatic logic [31:0] pick_reg_value(int which);
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;               // NaN
      2: return 32'h7F80_0000;               // +inf
      3: return 32'h7F7F_FFFF;               // overflows binary16
      4: return 32'h0000_0001;               // flushes to zero
      5: return 32'h3380_0000;               // binary16 subnormal
      6: return $urandom;
      default: begin
        case (which)
          REG_LR:    return 32'h3A83_126F;   // 1e-3
          REG_BETA1: return 32'h3F66_6666;
          REG_BETA2: return 32'h3F7F_BE77;
          REG_EPS:   return 32'h3586_37BD;
          default:   return 32'h3C23_D70A;   // 1e-2
        endcase
      end
    endcase
  endfunction

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t update;
  } directed_row_t;

  directed_row_t directed_rows[$];

  initial begin
    out_item_t none;
    in_item_t  x;
    int        sent, burst_left, gap;
    none = '0;

    // all zero: every path lands on +0
    directed_rows.push_back('{'{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
                              '{16'h0000, 16'h0000, 16'h0000}});
    // NaN gradient poisons all three outputs with the canonical NaN
    directed_rows.push_back('{'{16'h3C00, 16'h3C00, 16'h3C00, 16'h7FFF}, 1'b1,
                              '{F16_QNAN, F16_QNAN, F16_QNAN}});
    directed_rows.push_back('{'{16'h7BFF, 16'h7BFF, 16'h7BFF, 16'h7BFF}, 1'b0, none});
    directed_rows.push_back('{'{16'hFBFF, 16'hFBFF, 16'h7BFF, 16'hFBFF}, 1'b0, none});
    directed_rows.push_back('{'{16'h0001, 16'h0001, 16'h0001, 16'h0001}, 1'b0, none});
    directed_rows.push_back('{'{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b0, none});
    directed_rows.push_back('{'{16'h7C00, 16'h3C00, 16'h3C00, 16'h3C00}, 1'b0, none});
    directed_rows.push_back('{'{16'hFC00, 16'hFC00, 16'h7C00, 16'h0000}, 1'b0, none});
    // negative second moment: square root gives NaN
    directed_rows.push_back('{'{16'h3C00, 16'h3C00, 16'hBC00, 16'h0000}, 1'b0, none});
    // zero denominator with epsilon zero: divide by zero
    directed_rows.push_back('{'{16'h3C00, 16'h3C00, 16'h0000, 16'h0000}, 1'b0, none});
    directed_rows.push_back('{'{16'h3555, 16'h1234, 16'h03FF, 16'h83FF}, 1'b0, none});
    directed_rows.push_back('{'{16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA}, 1'b0, none});

    lr_bits    = LR_RESET;
    beta1_bits = BETA1_RESET;
    beta2_bits = BETA2_RESET;
    eps_bits   = EPS_RESET;
    decay_bits = DECAY_RESET;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, first under reset values, then with live settings.
    // Typed results hold only under reset values; the second pass predicts.
    for (int pass = 0; pass < 2; pass++) begin
      foreach (directed_rows[i])
        send_item(directed_rows[i].stim, directed_rows[i].typed && (pass == 0),
                  directed_rows[i].update);
      drain();
      phase_count++;
      if (pass == 0) begin
        write_reg(REG_LR, 32'h3F80_0000);
        write_reg(REG_EPS, 32'h0000_0000);
        write_reg(REG_DECAY, 32'h3C23_D70A);
        write_reg(CFG_UNUSED_IDX, 32'hDEAD_BEEF);
      end
    end

    // Random phases: the first two under fixed register settings, the rest with a random subset rewritten.
    sent = 0;
    burst_left = 0;
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 0) begin
        write_reg(REG_LR, 32'h3A83_126F);
        write_reg(REG_BETA1, 32'h3F66_6666);
        write_reg(REG_BETA2, 32'h3F7F_BE77);
        write_reg(REG_EPS, 32'h3586_37BD);
        write_reg(REG_DECAY, 32'h3C23_D70A);
      end else if (ph == 1) begin
        write_reg(REG_LR, 32'hFFFF_FFFF);
        write_reg(REG_BETA1, 32'h7F80_0000);
        write_reg(REG_BETA2, 32'h0000_0000);
        write_reg(REG_EPS, 32'h7F7F_FFFF);
        write_reg(REG_DECAY, 32'hFF80_0000);
      end else begin
        for (int r = 0; r < 5; r++)
          if ($urandom_range(2) != 0) write_reg(r[CFG_INDEX_W-1:0], pick_reg_value(r));
      end
      for (int k = 0; k < RANDOM_ITEMS / 7; k++) begin
        x.weight_in        = pick_half(6);
        x.first_moment_in  = pick_half(8);
        x.second_moment_in = (pick_half(10) & 16'h7FFF) |
                             {1'($urandom_range(19) == 0), 15'd0};
        x.gradient_in      = pick_half(6);
        send_item(x, 1'b0, none);
        sent++;
        // back up the whole pipeline once, with items still on offer
        if (ph == 3 && k == 10) long_hold_req = 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(24, 1);
          gap = (ph == 2) ? 0 : $urandom_range(6);
          if (gap != 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end else begin
          burst_left--;
        end
      end
      drain();
      phase_count++;
    end

    $display("Covered %0d items (%0d random) over %0d register settings, %0d results checked.",
             sent + 2 * directed_rows.size(), sent, phase_count, checked_count);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d updates pending", pending_updates.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
src/awd_pkg.sv
src/awd_root.sv
src/awd_div.sv
src/adam_weight_decay_update.sv
src/awd_check.sv
bench/tb_top.sv
